/* rtl/rwc_pkg.sv */
package rwc_pkg;

  localparam int unsigned TEXTURE_WIDTH  = 64;
  localparam int unsigned TEXTURE_HEIGHT = 64;
  localparam int unsigned FRAC_W         = 16;

  localparam int unsigned COL_W  = 12;
  localparam int unsigned CELL_W = 6;
  localparam int unsigned DIR_W  = 18;
  localparam int unsigned EYE_W  = 22;
  localparam int unsigned H_W    = 11;
  localparam int unsigned LH_W   = 16;
  localparam int unsigned ROW_W  = 11;
  localparam int unsigned TX_W   = 6;
  localparam int unsigned Q_W    = 23;

  // signed numerator ((cell + offset) << 16) - eye and its magnitude
  localparam int unsigned NUM_W  = CELL_W + 1 + FRAC_W + 1;
  localparam int unsigned MAG_W  = NUM_W - 1;
  localparam int unsigned D1_W   = MAG_W + FRAC_W;
  localparam int unsigned DIST_W = 40;
  localparam int unsigned D2_W   = H_W + FRAC_W;
  localparam int unsigned D3_W   = $clog2(TEXTURE_HEIGHT + 1) + FRAC_W;
  localparam int unsigned FRC_W  = 32;
  localparam int unsigned TXR_W  = $clog2(TEXTURE_WIDTH + 1);
  localparam int unsigned TXP_W  = FRC_W + TXR_W;
  localparam int unsigned OFF_W  = LH_W - 1;
  localparam int unsigned ST_W   = OFF_W + Q_W;

  localparam logic [DIST_W-1:0] DIST_MAX    = '1;
  localparam logic [LH_W-1:0]   LH_MAX      = '1;
  localparam logic [Q_W-1:0]    Q_MAX       = '1;
  localparam logic [H_W-1:0]    H_RESET     = H_W'(480);
  localparam logic [D3_W-1:0]   TH_DIVIDEND = D3_W'(TEXTURE_HEIGHT) << FRAC_W;

  typedef enum logic [1:0] {
    SIDE_EAST  = 2'd0,
    SIDE_WEST  = 2'd1,
    SIDE_NORTH = 2'd2,
    SIDE_SOUTH = 2'd3
  } side_e;

  typedef struct packed {
    logic [COL_W-1:0] column;
    side_e            side;
    logic [EYE_W-1:0] eye_o;
    logic [DIR_W-1:0] dir_o_mag;
    logic             dir_o_neg;
    logic [DIR_W-1:0] dir_mag;
    logic [MAG_W-1:0] num_mag;
    logic             dir_zero;
    logic             dist_zero;
  } front_item_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    side_e            side;
    logic [LH_W-1:0]  wall_height;
    logic [ROW_W-1:0] row_first;
    logic [ROW_W-1:0] row_last;
    logic [TX_W-1:0]  texel_column;
    logic [Q_W-1:0]   texel_step;
    logic [Q_W-1:0]   texel_start;
  } res_t;

endpackage

/* rtl/raycast_wall_column_setup.sv */
// Structure: accept loads the input register, then a 2-entry queue, 93 pipeline stages
//   and a result buffer.
// Throughput: one request per cycle while the result buffer has room; the three restoring
//   dividers retire one quotient bit per stage (39 + 27 + 23 stages).
// Reset: queues and pipeline empty, screen_height back to 480.
module raycast_wall_column_setup import rwc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [H_W-1:0]          cfg_wdata_i,
  input  logic                    push,
  output logic                    full,
  input  logic [COL_W-1:0]        column_i,
  input  logic [1:0]              hit_side_i,
  input  logic [CELL_W-1:0]       cell_x_i,
  input  logic [CELL_W-1:0]       cell_y_i,
  input  logic signed [1:0]       sign_x_i,
  input  logic signed [1:0]       sign_y_i,
  input  logic signed [DIR_W-1:0] ray_dir_x_i,
  input  logic signed [DIR_W-1:0] ray_dir_y_i,
  input  logic [EYE_W-1:0]        eye_x_i,
  input  logic [EYE_W-1:0]        eye_y_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [COL_W-1:0]        out_column_o,
  output logic [1:0]              texture_select_o,
  output logic [LH_W-1:0]         wall_height_o,
  output logic [ROW_W-1:0]        row_first_o,
  output logic [ROW_W-1:0]        row_last_o,
  output logic [TX_W-1:0]         texel_column_o,
  output logic [Q_W-1:0]          texel_step_o,
  output logic [Q_W-1:0]          texel_start_o
);

  logic [H_W-1:0] screen_height_q;
  logic           q_push, q_full, q_pop, q_empty;
  front_item_t    f_item, q_item;
  res_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q <= H_RESET;
    end else if (cfg_we_i) begin
      screen_height_q <= cfg_wdata_i;
    end
  end

  rwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .column_i    (column_i),
    .hit_side_i  (hit_side_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .sign_x_i    (sign_x_i),
    .sign_y_i    (sign_y_i),
    .ray_dir_x_i (ray_dir_x_i),
    .ray_dir_y_i (ray_dir_y_i),
    .eye_x_i     (eye_x_i),
    .eye_y_i     (eye_y_i),
    .q_push_o    (q_push),
    .q_full_i    (q_full),
    .item_o      (f_item)
  );

  rwc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .empty_o (q_empty)
  );

  rwc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .screen_height_i (screen_height_q),
    .item_i          (q_item),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .res_o           (res),
    .empty           (empty),
    .pop             (pop)
  );

  assign out_column_o     = res.column;
  assign texture_select_o = res.side;
  assign wall_height_o    = res.wall_height;
  assign row_first_o      = res.row_first;
  assign row_last_o       = res.row_last;
  assign texel_column_o   = res.texel_column;
  assign texel_step_o     = res.texel_step;
  assign texel_start_o    = res.texel_start;

endmodule

/* rtl/rwc_front.sv */
module rwc_front import rwc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [COL_W-1:0]        column_i,
  input  logic [1:0]              hit_side_i,
  input  logic [CELL_W-1:0]       cell_x_i,
  input  logic [CELL_W-1:0]       cell_y_i,
  input  logic signed [1:0]       sign_x_i,
  input  logic signed [1:0]       sign_y_i,
  input  logic signed [DIR_W-1:0] ray_dir_x_i,
  input  logic signed [DIR_W-1:0] ray_dir_y_i,
  input  logic [EYE_W-1:0]        eye_x_i,
  input  logic [EYE_W-1:0]        eye_y_i,
  output logic                    q_push_o,
  input  logic                    q_full_i,
  output front_item_t             item_o
);

  logic              ew;
  side_e             side;
  logic [CELL_W-1:0] map_cell;
  logic              off;
  logic [EYE_W-1:0]  eye;
  logic [DIR_W-1:0]  dir, dir_o, dir_neg, dir_o_neg;
  logic [CELL_W:0]   cell_off;
  logic [NUM_W-1:0]  num, num_neg;
  logic              load;
  logic              v_q, v_d;
  front_item_t       item_d, item_q;

  always_comb begin
    side      = side_e'(hit_side_i);
    ew        = (side == SIDE_EAST) || (side == SIDE_WEST);
    map_cell  = ew ? cell_x_i : cell_y_i;
    off       = ew ? sign_x_i[1] : sign_y_i[1];
    eye       = ew ? eye_x_i : eye_y_i;
    dir       = ew ? ray_dir_x_i : ray_dir_y_i;
    dir_o     = ew ? ray_dir_y_i : ray_dir_x_i;
    item_d.eye_o = ew ? eye_y_i : eye_x_i;
    cell_off  = {1'b0, map_cell} + {{CELL_W{1'b0}}, off};
    num       = {1'b0, cell_off, {FRAC_W{1'b0}}} - {2'b00, eye};
    num_neg   = -num;
    dir_neg   = -dir;
    dir_o_neg = -dir_o;
    item_d.column    = column_i;
    item_d.side      = side;
    item_d.dir_o_mag = dir_o[DIR_W-1] ? dir_o_neg : dir_o;
    item_d.dir_o_neg = dir_o[DIR_W-1];
    item_d.dir_mag   = dir[DIR_W-1] ? dir_neg : dir;
    item_d.num_mag   = num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
    item_d.dir_zero  = (dir == '0);
    // opposite signs mean the face lies behind the eye
    item_d.dist_zero = (num == '0) || (num[NUM_W-1] != dir[DIR_W-1]);
  end

  assign full     = v_q && q_full_i;
  assign load     = push && !full;
  assign q_push_o = v_q && !q_full_i;
  assign item_o   = item_q;

  always_comb begin
    v_d = v_q;
    if (load) begin
      v_d = 1'b1;
    end else if (q_push_o) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

endmodule

/* rtl/rwc_queue.sv */
module rwc_queue import rwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  front_item_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output front_item_t data_o,
  output logic        empty_o
);

  front_item_t slot_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/rwc_back.sv */
module rwc_back import rwc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [H_W-1:0]   screen_height_i,
  input  front_item_t      item_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  output res_t             res_o,
  output logic             empty,
  input  logic             pop
);

  typedef struct packed {
    logic [COL_W-1:0] column;
    side_e            side;
    logic [EYE_W-1:0] eye_o;
    logic [DIR_W-1:0] dir_o_mag;
    logic             dir_o_neg;
    logic             dir_zero;
    logic             dist_zero;
    logic [DIR_W-1:0] dmag;
    logic [MAG_W-1:0] nmag;
    logic [DIR_W-1:0] rem;
    logic [D1_W-1:0]  quo;
  } p1_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    side_e             side;
    logic [FRAC_W-1:0] eye_lo;
    logic              dir_o_neg;
    logic [FRC_W-1:0]  prod;
    logic [DIST_W-1:0] wall_dist;
  } m1_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    side_e             side;
    logic [TX_W-1:0]   tx;
    logic [DIST_W-1:0] wall_dist;
    logic [DIST_W-1:0] rem;
    logic [D2_W-1:0]   quo;
  } p2_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    side_e            side;
    logic [TX_W-1:0]  tx;
    logic [LH_W-1:0]  lh;
    logic [ROW_W-1:0] first;
    logic [ROW_W-1:0] last;
    logic [OFF_W-1:0] rows_off;
    logic [LH_W-1:0]  rem;
    logic [D3_W-1:0]  quo;
  } p3_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    side_e            side;
    logic [TX_W-1:0]  tx;
    logic [LH_W-1:0]  lh;
    logic [ROW_W-1:0] first;
    logic [ROW_W-1:0] last;
    logic [OFF_W-1:0] rows_off;
    logic [Q_W-1:0]   step;
  } s_t;

  logic adv;

  // ---------------- distance divider ----------------
  p1_t  head1;
  p1_t  p1_q [D1_W];
  logic v1_q [D1_W];

  always_comb begin
    head1.column    = item_i.column;
    head1.side      = item_i.side;
    head1.eye_o     = item_i.eye_o;
    head1.dir_o_mag = item_i.dir_o_mag;
    head1.dir_o_neg = item_i.dir_o_neg;
    head1.dir_zero  = item_i.dir_zero;
    head1.dist_zero = item_i.dist_zero;
    head1.dmag      = item_i.dir_mag;
    head1.nmag      = item_i.num_mag;
    head1.rem       = '0;
    head1.quo       = '0;
  end

  assign q_pop_o = adv && !q_empty_i;

  for (genvar k = 0; k < D1_W; k++) begin : g_div1
    p1_t             src, nxt;
    logic            src_v;
    logic [D1_W-1:0] dvd;
    logic [DIR_W:0]  trial, diff;
    logic            fits;

    if (k == 0) begin : g_head
      assign src   = head1;
      assign src_v = !q_empty_i;
    end else begin : g_link
      assign src   = p1_q[k-1];
      assign src_v = v1_q[k-1];
    end

    always_comb begin
      nxt     = src;
      dvd     = {src.nmag, {FRAC_W{1'b0}}};
      trial   = {src.rem, dvd[D1_W-1-k]};
      diff    = trial - {1'b0, src.dmag};
      fits    = (trial >= {1'b0, src.dmag});
      nxt.rem = fits ? diff[DIR_W-1:0] : trial[DIR_W-1:0];
      nxt.quo = {src.quo[D1_W-2:0], fits};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q[k] <= 1'b0;
      end else if (adv) begin
        v1_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        p1_q[k] <= nxt;
      end
    end
  end

  // ---------------- hit point, texture column ----------------
  p1_t               t1;
  m1_t               m1_d, m1_q;
  logic              m1_v_q;
  logic [DIST_W-1:0] dist_sel;

  assign t1 = p1_q[D1_W-1];

  always_comb begin
    if (t1.dir_zero) begin
      dist_sel = DIST_MAX;
    end else if (t1.dist_zero) begin
      dist_sel = '0;
    end else begin
      dist_sel = DIST_W'(t1.quo);
    end
    m1_d.column    = t1.column;
    m1_d.side      = t1.side;
    m1_d.eye_lo    = t1.eye_o[FRAC_W-1:0];
    m1_d.dir_o_neg = t1.dir_o_neg;
    m1_d.wall_dist = dist_sel;
    // only the low word of the hit point feeds the fraction
    m1_d.prod      = FRC_W'(dist_sel[FRC_W-1:0] * t1.dir_o_mag);
  end

  p2_t              m2_d, m2_q;
  logic             m2_v_q;
  logic [FRC_W-1:0] prod_s, frac;
  logic [TXP_W-1:0] txp;
  logic [TXR_W-1:0] tx_raw, tx_m;

  always_comb begin
    prod_s = m1_q.dir_o_neg ? -m1_q.prod : m1_q.prod;
    frac   = {m1_q.eye_lo, {FRAC_W{1'b0}}} + prod_s;
    txp    = TXP_W'(frac) * TXP_W'(TEXTURE_WIDTH);
    tx_raw = txp[TXP_W-1:FRC_W];
    // mirror east and south faces
    if ((m1_q.side == SIDE_EAST) || (m1_q.side == SIDE_SOUTH)) begin
      tx_m = TXR_W'(TEXTURE_WIDTH - 1) - tx_raw;
    end else begin
      tx_m = tx_raw;
    end
    m2_d.column    = m1_q.column;
    m2_d.side      = m1_q.side;
    m2_d.tx        = TX_W'(tx_m);
    m2_d.wall_dist = m1_q.wall_dist;
    m2_d.rem       = '0;
    m2_d.quo       = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= v1_q[D1_W-1];
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
  end

  // ---------------- wall height divider ----------------
  p2_t  p2_q [D2_W];
  logic v2_q [D2_W];
  logic [D2_W-1:0] dvd2;

  assign dvd2 = {screen_height_i, {FRAC_W{1'b0}}};

  for (genvar k = 0; k < D2_W; k++) begin : g_div2
    p2_t             src, nxt;
    logic            src_v;
    logic [DIST_W:0] trial, diff;
    logic            fits;

    if (k == 0) begin : g_head
      assign src   = m2_q;
      assign src_v = m2_v_q;
    end else begin : g_link
      assign src   = p2_q[k-1];
      assign src_v = v2_q[k-1];
    end

    always_comb begin
      nxt     = src;
      trial   = {src.rem, dvd2[D2_W-1-k]};
      diff    = trial - {1'b0, src.wall_dist};
      fits    = (trial >= {1'b0, src.wall_dist});
      nxt.rem = fits ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
      nxt.quo = {src.quo[D2_W-2:0], fits};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v2_q[k] <= 1'b0;
      end else if (adv) begin
        v2_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        p2_q[k] <= nxt;
      end
    end
  end

  // ---------------- wall height, draw rows ----------------
  p2_t              t2;
  p3_t              l_d, l_q;
  logic             l_v_q;
  logic [LH_W-1:0]  lh;
  logic [OFF_W-1:0] h2, l2;
  logic [LH_W-1:0]  sum;

  assign t2 = p2_q[D2_W-1];

  always_comb begin
    if ((t2.wall_dist == '0) || (t2.quo[D2_W-1:LH_W] != '0)) begin
      lh = LH_MAX;
    end else begin
      lh = t2.quo[LH_W-1:0];
    end
    h2  = OFF_W'(screen_height_i[H_W-1:1]);
    l2  = lh[LH_W-1:1];
    sum = {1'b0, h2} + {1'b0, l2};
    l_d.column   = t2.column;
    l_d.side     = t2.side;
    l_d.tx       = t2.tx;
    l_d.lh       = lh;
    l_d.first    = (h2 > l2) ? ROW_W'(h2 - l2) : '0;
    l_d.rows_off = (l2 > h2) ? (l2 - h2) : '0;
    if (screen_height_i == '0) begin
      l_d.last = '0;
    end else if (sum >= LH_W'(screen_height_i)) begin
      l_d.last = screen_height_i - H_W'(1);
    end else begin
      l_d.last = ROW_W'(sum);
    end
    l_d.rem = '0;
    l_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_v_q <= 1'b0;
    end else if (adv) begin
      l_v_q <= v2_q[D2_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_q <= l_d;
    end
  end

  // ---------------- texture step divider ----------------
  p3_t  p3_q [D3_W];
  logic v3_q [D3_W];

  for (genvar k = 0; k < D3_W; k++) begin : g_div3
    p3_t           src, nxt;
    logic          src_v;
    logic [LH_W:0] trial, diff;
    logic          fits;

    if (k == 0) begin : g_head
      assign src   = l_q;
      assign src_v = l_v_q;
    end else begin : g_link
      assign src   = p3_q[k-1];
      assign src_v = v3_q[k-1];
    end

    always_comb begin
      nxt     = src;
      trial   = {src.rem, TH_DIVIDEND[D3_W-1-k]};
      diff    = trial - {1'b0, src.lh};
      fits    = (trial >= {1'b0, src.lh});
      nxt.rem = fits ? diff[LH_W-1:0] : trial[LH_W-1:0];
      nxt.quo = {src.quo[D3_W-2:0], fits};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v3_q[k] <= 1'b0;
      end else if (adv) begin
        v3_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        p3_q[k] <= nxt;
      end
    end
  end

  // ---------------- texture step ----------------
  p3_t  t3;
  s_t   s_d, s_q;
  logic s_v_q;

  assign t3 = p3_q[D3_W-1];

  always_comb begin
    s_d.column   = t3.column;
    s_d.side     = t3.side;
    s_d.tx       = t3.tx;
    s_d.lh       = t3.lh;
    s_d.first    = t3.first;
    s_d.last     = t3.last;
    s_d.rows_off = t3.rows_off;
    if ((t3.lh == '0) || (64'(t3.quo) > 64'(Q_MAX))) begin
      s_d.step = Q_MAX;
    end else begin
      s_d.step = Q_W'(t3.quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (adv) begin
      s_v_q <= v3_q[D3_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= s_d;
    end
  end

  // ---------------- start position, result buffer ----------------
  res_t            res_d;
  logic [ST_W-1:0] start_p;

  always_comb begin
    start_p            = ST_W'(s_q.rows_off) * ST_W'(s_q.step);
    res_d.column       = s_q.column;
    res_d.side         = s_q.side;
    res_d.wall_height  = s_q.lh;
    res_d.row_first    = s_q.first;
    res_d.row_last     = s_q.last;
    res_d.texel_column = s_q.tx;
    res_d.texel_step   = s_q.step;
    res_d.texel_start  = (start_p > ST_W'(Q_MAX)) ? Q_MAX : start_p[Q_W-1:0];
  end

  res_t       obuf_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q, ocnt_d;
  logic       opush, opop;

  // hold the whole pipeline only when the buffer is full and a result waits
  assign adv    = !s_v_q || (ocnt_q != 2'd2);
  assign opush  = adv && s_v_q;
  assign empty  = (ocnt_q == 2'd0);
  assign opop   = pop && !empty;
  assign res_o  = obuf_q[ord_q];
  assign ocnt_d = ocnt_q + {1'b0, opush} - {1'b0, opop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      owr_q  <= opush ? ~owr_q : owr_q;
      ord_q  <= opop ? ~ord_q : ord_q;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      obuf_q[owr_q] <= res_d;
    end
  end

endmodule
